### design/magnify_lens_coordinate_remap_top_macros.svh
// Assertion macros for the lens coordinate remapper
`ifndef MAGNIFY_LENS_COORDINATE_REMAP_TOP_MACROS_SVH
`define MAGNIFY_LENS_COORDINATE_REMAP_TOP_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MLCR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with a fixed delay in cycles
`define MLCR_ASSERT_DLY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

### design/mlcr_pkg.sv
// Types, constants and helpers for the lens coordinate remapper
`default_nettype none
package mlcr_pkg;

    localparam int MAX_DIM  = 4096;
    localparam int DIM_W    = 13;
    localparam int COORD_W  = 12;
    localparam int APB_AW   = 5;

    localparam int CXP_W    = 30;   // center fraction times frame size
    localparam int CX_W     = 21;   // Q8 center
    localparam int D_W      = 23;   // signed Q8 offset
    localparam int DM_W     = 22;   // offset magnitude
    localparam int RAD_W    = 44;   // squared distance
    localparam int DIST_W   = 22;
    localparam int RREM_W   = 24;   // root remainder
    localparam int MAXR_W   = 21;
    localparam int PR_W     = 27;   // operand of the divide-by-100
    localparam int DPROD_W  = 55;
    localparam int INM_W    = 36;
    localparam int FD_W     = 15;
    localparam int DEN_W    = 22;
    localparam int BLEND_W  = 16;
    localparam int MPROD_W  = 30;
    localparam int SCALE_W  = 16;
    localparam int SRC_Q_W  = 34;
    localparam int SRC_R_W  = 16;
    localparam int SUM_W    = 36;

    localparam int SQRT_STEPS  = DIST_W;
    localparam int BLEND_STEPS = BLEND_W;
    localparam int SRC_STEPS   = SRC_Q_W;
    // accept edge to the edge that takes the result
    localparam int PIPE_LAT    = 5 + SQRT_STEPS + 1 + BLEND_STEPS + 2 + SRC_STEPS + 2;

    // floor(p / 100) = (p * DIV100_MUL) >> DIV100_SHIFT for p below 2**30
    localparam logic [27:0] DIV100_MUL   = 28'd171798692;
    localparam int          DIV100_SHIFT = 34;
    localparam logic [FD_W-1:0] FEATHER_FULL = 15'd25600;

    localparam logic [16:0]      RST_CENTER_X = 17'd32768;
    localparam logic [16:0]      RST_CENTER_Y = 17'd32768;
    localparam logic [10:0]      RST_MAG      = 11'd512;
    localparam logic [14:0]      RST_RADIUS   = 15'd7680;
    localparam logic [14:0]      RST_FEATHER  = 15'd12800;
    localparam logic [DIM_W-1:0] RST_WIDTH    = 13'd640;
    localparam logic [DIM_W-1:0] RST_HEIGHT   = 13'd480;

    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_MAG      = 3'd2,
        REG_RADIUS   = 3'd3,
        REG_FEATHER  = 3'd4,
        REG_WIDTH    = 3'd5,
        REG_HEIGHT   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic               in_lens;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic signed [D_W-1:0] dx;
        logic signed [D_W-1:0] dy;
    } t_carry;

    // Q8 sum to pixel, clamped to 0..lim; outside the lens the pixel maps to itself, clamped to lim
    function automatic logic [COORD_W-1:0] clamp_src(
        input logic signed [SUM_W-1:0] sum,
        input logic [COORD_W-1:0]      pix,
        input logic                    in_lens,
        input logic [DIM_W-1:0]        lim
    );
        logic [SUM_W-9:0]   v;
        logic [COORD_W-1:0] res;
        v = sum[SUM_W-1:8];
        if (!in_lens) begin
            res = ({1'b0, pix} > lim) ? lim[COORD_W-1:0] : pix;
        end else if (sum < 0) begin
            res = '0;
        end else if (v > (SUM_W-8)'(lim)) begin
            res = lim[COORD_W-1:0];
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### design/magnify_lens_coordinate_remap_top.sv
// Lens coordinate remapper: APB registers and the per-pixel remap pipeline
// Usage:
//   Pulse start with an output pixel on i_item; busy is never raised, so one
//   transaction can enter every cycle. Each transaction returns one result on
//   o_result, marked by o_valid for a single cycle; the receiver has no way to
//   stall it and must take it.
//   Throughput is one pixel per clock. The pipeline's length is set by the
//   22-step square root, the 16-step blend divider and the 34-step source
//   dividers, each retiring one bit per stage.
//   Registers sit on the APB port (byte address 4*index); write them only
//   while no transaction is in flight. Derived lens values settle after a
//   write, ahead of any pixel that needs them.
//   Reset (synchronous, active low) loads the register defaults and clears
//   every valid bit in the pipeline; nothing in flight survives it.
`default_nettype none
`include "magnify_lens_coordinate_remap_top_macros.svh"
module magnify_lens_coordinate_remap_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  mlcr_pkg::t_in_item                 i_item,
    output logic                               o_valid,
    output mlcr_pkg::t_out_item                o_result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mlcr_pkg::APB_AW-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import mlcr_pkg::*;

    // ---------------- configuration registers ----------------
    logic [16:0]      r_cx_frac;
    logic [16:0]      r_cy_frac;
    logic [10:0]      r_mag;
    logic [14:0]      r_radius;
    logic [14:0]      r_feather;
    logic [DIM_W-1:0] r_fw;
    logic [DIM_W-1:0] r_fh;
    logic             w_wr;
    t_reg_idx         w_idx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx_frac <= RST_CENTER_X;
            r_cy_frac <= RST_CENTER_Y;
            r_mag     <= RST_MAG;
            r_radius  <= RST_RADIUS;
            r_feather <= RST_FEATHER;
            r_fw      <= RST_WIDTH;
            r_fh      <= RST_HEIGHT;
        end else if (w_wr) begin
            case (w_idx)
                REG_CENTER_X: r_cx_frac <= pwdata[16:0];
                REG_CENTER_Y: r_cy_frac <= pwdata[16:0];
                REG_MAG:      r_mag     <= pwdata[10:0];
                REG_RADIUS:   r_radius  <= pwdata[14:0];
                REG_FEATHER:  r_feather <= pwdata[14:0];
                REG_WIDTH:    r_fw      <= pwdata[DIM_W-1:0];
                REG_HEIGHT:   r_fh      <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CENTER_X: prdata = {15'd0, r_cx_frac};
            REG_CENTER_Y: prdata = {15'd0, r_cy_frac};
            REG_MAG:      prdata = {21'd0, r_mag};
            REG_RADIUS:   prdata = {17'd0, r_radius};
            REG_FEATHER:  prdata = {17'd0, r_feather};
            REG_WIDTH:    prdata = {19'd0, r_fw};
            REG_HEIGHT:   prdata = {19'd0, r_fh};
            default:      prdata = '0;
        endcase
    end

    // ---------------- derived lens values (free running) ----------------
    logic [DIM_W-1:0]        n_w, n_h, n_side;
    logic [FD_W-1:0]         n_fdiff;
    logic [MAXR_W-1:0]       n_inner_mag;
    logic [DIM_W-1:0]        r_w, r_h;
    logic [PR_W-1:0]         r_pr;
    logic [CXP_W-1:0]        r_cxp, r_cyp;
    logic [CX_W-1:0]         r_cx, r_cy;
    logic [DPROD_W-1:0]      r_mr_prod;
    logic [MAXR_W-1:0]       r_max_r;
    logic [INM_W-1:0]        r_in_mag;
    logic                    r_in_neg, r_in_neg2;
    logic [DPROD_W-1:0]      r_in_prod;
    logic signed [D_W-1:0]   r_inner;
    logic [DEN_W-1:0]        r_denom;
    logic signed [11:0]      w_mag_off;
    logic                    w_feat_on;

    always_comb begin
        if (r_fw == '0)                      n_w = DIM_W'(1);
        else if (r_fw > DIM_W'(MAX_DIM))     n_w = DIM_W'(MAX_DIM);
        else                                 n_w = r_fw;
        if (r_fh == '0)                      n_h = DIM_W'(1);
        else if (r_fh > DIM_W'(MAX_DIM))     n_h = DIM_W'(MAX_DIM);
        else                                 n_h = r_fh;
        n_side  = (n_w > n_h) ? n_w : n_h;
        n_fdiff = (r_feather > FEATHER_FULL) ? (r_feather - FEATHER_FULL)
                                             : (FEATHER_FULL - r_feather);
        n_inner_mag = r_in_prod[DIV100_SHIFT+MAXR_W-1:DIV100_SHIFT];
    end

    assign w_mag_off = $signed({1'b0, r_mag}) - 12'sd256;
    assign w_feat_on = (r_feather != '0);

    always_ff @(posedge i_clk) begin
        r_w       <= n_w;
        r_h       <= n_h;
        r_pr      <= PR_W'(r_radius * n_side);
        r_cxp     <= CXP_W'(r_cx_frac * n_w);
        r_cyp     <= CXP_W'(r_cy_frac * n_h);
        r_cx      <= r_cxp[CX_W+7:8];
        r_cy      <= r_cyp[CX_W+7:8];
        r_mr_prod <= DPROD_W'(r_pr * DIV100_MUL);
        r_max_r   <= r_mr_prod[DIV100_SHIFT+MAXR_W-1:DIV100_SHIFT];
        r_in_mag  <= INM_W'(r_max_r * n_fdiff);
        r_in_neg  <= (r_feather > FEATHER_FULL);
        // divide by 25600 = shift by 8, then divide by 100
        r_in_prod <= DPROD_W'(r_in_mag[PR_W+7:8] * DIV100_MUL);
        r_in_neg2 <= r_in_neg;
        if (r_in_neg2) begin
            r_inner <= -$signed({2'b00, n_inner_mag});
            r_denom <= DEN_W'(r_max_r + n_inner_mag);
        end else begin
            r_inner <= $signed({2'b00, n_inner_mag});
            r_denom <= DEN_W'(r_max_r - n_inner_mag);
        end
    end

    // ---------------- front: offsets and squares ----------------
    logic                    r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [COORD_W-1:0]      r_x1, r_y1, r_x2, r_y2;
    t_carry                  r_c3, r_c4, r_c5;
    logic [DM_W-1:0]         n_magx, n_magy;
    logic [RAD_W-1:0]        r_sqx, r_sqy, r_rad;

    always_comb begin
        n_magx = r_c3.dx[D_W-1] ? DM_W'(-r_c3.dx) : r_c3.dx[DM_W-1:0];
        n_magy = r_c3.dy[D_W-1] ? DM_W'(-r_c3.dy) : r_c3.dy[DM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= start & ~busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1    <= i_item.out_x;
        r_y1    <= i_item.out_y;
        r_x2    <= r_x1;
        r_y2    <= r_y1;
        r_c3.x  <= r_x2;
        r_c3.y  <= r_y2;
        r_c3.dx <= $signed({3'b000, r_x2, 8'h00}) - $signed({2'b00, r_cx});
        r_c3.dy <= $signed({3'b000, r_y2, 8'h00}) - $signed({2'b00, r_cy});
        r_sqx   <= RAD_W'(n_magx * n_magx);
        r_sqy   <= RAD_W'(n_magy * n_magy);
        r_c4    <= r_c3;
        r_rad   <= r_sqx + r_sqy;
        r_c5    <= r_c4;
    end

    // ---------------- square root, one result bit per stage ----------------
    logic                r_sq_v    [SQRT_STEPS];
    logic [RAD_W-1:0]    r_sq_rad  [SQRT_STEPS];
    logic [RREM_W-1:0]   r_sq_rem  [SQRT_STEPS];
    logic [DIST_W-1:0]   r_sq_root [SQRT_STEPS];
    t_carry              r_sq_c    [SQRT_STEPS];
    logic                w_sq_v    [SQRT_STEPS];
    logic [RAD_W-1:0]    w_sq_rad  [SQRT_STEPS];
    logic [RREM_W-1:0]   w_sq_rem  [SQRT_STEPS];
    logic [DIST_W-1:0]   w_sq_root [SQRT_STEPS];
    t_carry              w_sq_c    [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic [RREM_W+1:0] w_rs;
        logic [RREM_W+1:0] w_trial;
        logic              w_ge;

        if (k == 0) begin : g_first
            assign w_sq_v[k]    = r_v5;
            assign w_sq_rad[k]  = r_rad;
            assign w_sq_rem[k]  = '0;
            assign w_sq_root[k] = '0;
            assign w_sq_c[k]    = r_c5;
        end else begin : g_next
            assign w_sq_v[k]    = r_sq_v[k-1];
            assign w_sq_rad[k]  = r_sq_rad[k-1];
            assign w_sq_rem[k]  = r_sq_rem[k-1];
            assign w_sq_root[k] = r_sq_root[k-1];
            assign w_sq_c[k]    = r_sq_c[k-1];
        end

        assign w_rs    = {w_sq_rem[k], w_sq_rad[k][RAD_W-1 -: 2]};
        assign w_trial = (RREM_W+2)'({w_sq_root[k], 2'b01});
        assign w_ge    = (w_rs >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else begin
                r_sq_v[k] <= w_sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_rad[k]  <= w_sq_rad[k] << 2;
            r_sq_rem[k]  <= w_ge ? RREM_W'(w_rs - w_trial) : w_rs[RREM_W-1:0];
            r_sq_root[k] <= {w_sq_root[k][DIST_W-2:0], w_ge};
            r_sq_c[k]    <= w_sq_c[k];
        end
    end

    // ---------------- lens test ----------------
    logic              r_cm_v, r_cm_in, r_cm_ft;
    logic [DEN_W-1:0]  r_cm_num;
    t_carry            r_cm_c;
    logic [DIST_W-1:0] w_dist;

    assign w_dist = r_sq_root[SQRT_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cm_v <= 1'b0;
        end else begin
            r_cm_v <= r_sq_v[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cm_in  <= (w_dist < DIST_W'(r_max_r));
        r_cm_ft  <= ($signed({1'b0, w_dist}) > r_inner) && w_feat_on;
        r_cm_num <= DEN_W'(r_max_r - w_dist);
        r_cm_c   <= r_sq_c[SQRT_STEPS-1];
    end

    // ---------------- feather blend divider ----------------
    logic                r_bl_v   [BLEND_STEPS];
    logic                r_bl_in  [BLEND_STEPS];
    logic                r_bl_ft  [BLEND_STEPS];
    logic [DEN_W-1:0]    r_bl_rem [BLEND_STEPS];
    logic [BLEND_W-1:0]  r_bl_q   [BLEND_STEPS];
    t_carry              r_bl_c   [BLEND_STEPS];
    logic                w_bl_v   [BLEND_STEPS];
    logic                w_bl_in  [BLEND_STEPS];
    logic                w_bl_ft  [BLEND_STEPS];
    logic [DEN_W-1:0]    w_bl_rem [BLEND_STEPS];
    logic [BLEND_W-1:0]  w_bl_q   [BLEND_STEPS];
    t_carry              w_bl_c   [BLEND_STEPS];

    for (genvar k = 0; k < BLEND_STEPS; k++) begin : g_blend
        logic [DEN_W:0] w_rs;
        logic           w_ge;

        if (k == 0) begin : g_first
            assign w_bl_v[k]   = r_cm_v;
            assign w_bl_in[k]  = r_cm_in;
            assign w_bl_ft[k]  = r_cm_ft;
            assign w_bl_rem[k] = r_cm_num;
            assign w_bl_q[k]   = '0;
            assign w_bl_c[k]   = r_cm_c;
        end else begin : g_next
            assign w_bl_v[k]   = r_bl_v[k-1];
            assign w_bl_in[k]  = r_bl_in[k-1];
            assign w_bl_ft[k]  = r_bl_ft[k-1];
            assign w_bl_rem[k] = r_bl_rem[k-1];
            assign w_bl_q[k]   = r_bl_q[k-1];
            assign w_bl_c[k]   = r_bl_c[k-1];
        end

        assign w_rs = {w_bl_rem[k], 1'b0};
        assign w_ge = (w_rs >= {1'b0, r_denom});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_bl_v[k] <= 1'b0;
            end else begin
                r_bl_v[k] <= w_bl_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_bl_in[k]  <= w_bl_in[k];
            r_bl_ft[k]  <= w_bl_ft[k];
            r_bl_rem[k] <= w_ge ? DEN_W'(w_rs - {1'b0, r_denom}) : w_rs[DEN_W-1:0];
            r_bl_q[k]   <= {w_bl_q[k][BLEND_W-2:0], w_ge};
            r_bl_c[k]   <= w_bl_c[k];
        end
    end

    // ---------------- scale ----------------
    logic                      r_mu_v, r_mu_in;
    logic signed [MPROD_W-1:0] r_mu_prod;
    t_carry                    r_mu_c;
    logic [BLEND_W:0]          w_blend;
    logic signed [MPROD_W-1:0] n_t, n_sc;
    logic [DM_W-1:0]           n_mx, n_my;
    logic                      r_sc_v, r_sc_in, r_sc_negx, r_sc_negy;
    logic [SCALE_W-1:0]        r_sc_scale;
    logic [SRC_Q_W-1:0]        r_sc_nx, r_sc_ny;
    logic [COORD_W-1:0]        r_sc_x, r_sc_y;

    assign w_blend = r_bl_ft[BLEND_STEPS-1] ? {1'b0, r_bl_q[BLEND_STEPS-1]}
                                            : {1'b1, {BLEND_W{1'b0}}};

    always_comb begin
        // truncate toward zero on the divide by 4096
        if (r_mu_prod < 0) n_t = (r_mu_prod + 30'sd4095) >>> 12;
        else               n_t = r_mu_prod >>> 12;
        n_sc = n_t + 30'sd4096;
        n_mx = r_mu_c.dx[D_W-1] ? DM_W'(-r_mu_c.dx) : r_mu_c.dx[DM_W-1:0];
        n_my = r_mu_c.dy[D_W-1] ? DM_W'(-r_mu_c.dy) : r_mu_c.dy[DM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu_v <= 1'b0;
            r_sc_v <= 1'b0;
        end else begin
            r_mu_v <= r_bl_v[BLEND_STEPS-1];
            r_sc_v <= r_mu_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mu_in    <= r_bl_in[BLEND_STEPS-1];
        r_mu_prod  <= MPROD_W'(w_mag_off * $signed({1'b0, w_blend}));
        r_mu_c     <= r_bl_c[BLEND_STEPS-1];
        r_sc_in    <= r_mu_in;
        r_sc_scale <= (n_sc < 30'sd1) ? SCALE_W'(1) : n_sc[SCALE_W-1:0];
        r_sc_nx    <= {n_mx, 12'h000};
        r_sc_ny    <= {n_my, 12'h000};
        r_sc_negx  <= r_mu_c.dx[D_W-1];
        r_sc_negy  <= r_mu_c.dy[D_W-1];
        r_sc_x     <= r_mu_c.x;
        r_sc_y     <= r_mu_c.y;
    end

    // ---------------- offset / scale dividers, x and y side by side ----------------
    logic                r_dv_v   [SRC_STEPS];
    logic                r_dv_in  [SRC_STEPS];
    logic                r_dv_ngx [SRC_STEPS];
    logic                r_dv_ngy [SRC_STEPS];
    logic [SCALE_W-1:0]  r_dv_sc  [SRC_STEPS];
    logic [SRC_Q_W-1:0]  r_dv_nx  [SRC_STEPS];
    logic [SRC_Q_W-1:0]  r_dv_ny  [SRC_STEPS];
    logic [SRC_R_W-1:0]  r_dv_rx  [SRC_STEPS];
    logic [SRC_R_W-1:0]  r_dv_ry  [SRC_STEPS];
    logic [COORD_W-1:0]  r_dv_x   [SRC_STEPS];
    logic [COORD_W-1:0]  r_dv_y   [SRC_STEPS];
    logic                w_dv_v   [SRC_STEPS];
    logic                w_dv_in  [SRC_STEPS];
    logic                w_dv_ngx [SRC_STEPS];
    logic                w_dv_ngy [SRC_STEPS];
    logic [SCALE_W-1:0]  w_dv_sc  [SRC_STEPS];
    logic [SRC_Q_W-1:0]  w_dv_nx  [SRC_STEPS];
    logic [SRC_Q_W-1:0]  w_dv_ny  [SRC_STEPS];
    logic [SRC_R_W-1:0]  w_dv_rx  [SRC_STEPS];
    logic [SRC_R_W-1:0]  w_dv_ry  [SRC_STEPS];
    logic [COORD_W-1:0]  w_dv_x   [SRC_STEPS];
    logic [COORD_W-1:0]  w_dv_y   [SRC_STEPS];

    for (genvar k = 0; k < SRC_STEPS; k++) begin : g_div
        logic [SRC_R_W:0] w_rsx, w_rsy, w_den;
        logic             w_gex, w_gey;

        if (k == 0) begin : g_first
            assign w_dv_v[k]   = r_sc_v;
            assign w_dv_in[k]  = r_sc_in;
            assign w_dv_ngx[k] = r_sc_negx;
            assign w_dv_ngy[k] = r_sc_negy;
            assign w_dv_sc[k]  = r_sc_scale;
            assign w_dv_nx[k]  = r_sc_nx;
            assign w_dv_ny[k]  = r_sc_ny;
            assign w_dv_rx[k]  = '0;
            assign w_dv_ry[k]  = '0;
            assign w_dv_x[k]   = r_sc_x;
            assign w_dv_y[k]   = r_sc_y;
        end else begin : g_next
            assign w_dv_v[k]   = r_dv_v[k-1];
            assign w_dv_in[k]  = r_dv_in[k-1];
            assign w_dv_ngx[k] = r_dv_ngx[k-1];
            assign w_dv_ngy[k] = r_dv_ngy[k-1];
            assign w_dv_sc[k]  = r_dv_sc[k-1];
            assign w_dv_nx[k]  = r_dv_nx[k-1];
            assign w_dv_ny[k]  = r_dv_ny[k-1];
            assign w_dv_rx[k]  = r_dv_rx[k-1];
            assign w_dv_ry[k]  = r_dv_ry[k-1];
            assign w_dv_x[k]   = r_dv_x[k-1];
            assign w_dv_y[k]   = r_dv_y[k-1];
        end

        assign w_den = {1'b0, w_dv_sc[k]};
        assign w_rsx = {w_dv_rx[k], w_dv_nx[k][SRC_Q_W-1]};
        assign w_rsy = {w_dv_ry[k], w_dv_ny[k][SRC_Q_W-1]};
        assign w_gex = (w_rsx >= w_den);
        assign w_gey = (w_rsy >= w_den);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k] <= 1'b0;
            end else begin
                r_dv_v[k] <= w_dv_v[k];
            end
        end

        // numerator shifts out at the top while quotient bits shift in
        always_ff @(posedge i_clk) begin
            r_dv_in[k]  <= w_dv_in[k];
            r_dv_ngx[k] <= w_dv_ngx[k];
            r_dv_ngy[k] <= w_dv_ngy[k];
            r_dv_sc[k]  <= w_dv_sc[k];
            r_dv_nx[k]  <= {w_dv_nx[k][SRC_Q_W-2:0], w_gex};
            r_dv_ny[k]  <= {w_dv_ny[k][SRC_Q_W-2:0], w_gey};
            r_dv_rx[k]  <= w_gex ? SRC_R_W'(w_rsx - w_den) : w_rsx[SRC_R_W-1:0];
            r_dv_ry[k]  <= w_gey ? SRC_R_W'(w_rsy - w_den) : w_rsy[SRC_R_W-1:0];
            r_dv_x[k]   <= w_dv_x[k];
            r_dv_y[k]   <= w_dv_y[k];
        end
    end

    // ---------------- recenter, clamp, output ----------------
    localparam int LD = SRC_STEPS - 1;

    logic                    r_su_v, r_su_in;
    logic signed [SUM_W-1:0] r_su_x, r_su_y;
    logic [COORD_W-1:0]      r_su_px, r_su_py;
    logic signed [SUM_W-1:0] w_cxs, w_cys, w_qx, w_qy;
    logic [DIM_W-1:0]        w_wm1, w_hm1;
    logic                    r_out_v;
    t_out_item               r_out;

    assign w_cxs = $signed({{(SUM_W-CX_W){1'b0}}, r_cx});
    assign w_cys = $signed({{(SUM_W-CX_W){1'b0}}, r_cy});
    assign w_qx  = $signed({{(SUM_W-SRC_Q_W){1'b0}}, r_dv_nx[LD]});
    assign w_qy  = $signed({{(SUM_W-SRC_Q_W){1'b0}}, r_dv_ny[LD]});
    assign w_wm1 = r_w - DIM_W'(1);
    assign w_hm1 = r_h - DIM_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_su_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_su_v  <= r_dv_v[LD];
            r_out_v <= r_su_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_su_in       <= r_dv_in[LD];
        r_su_x        <= r_dv_ngx[LD] ? (w_cxs - w_qx) : (w_cxs + w_qx);
        r_su_y        <= r_dv_ngy[LD] ? (w_cys - w_qy) : (w_cys + w_qy);
        r_su_px       <= r_dv_x[LD];
        r_su_py       <= r_dv_y[LD];
        r_out.src_x   <= clamp_src(r_su_x, r_su_px, r_su_in, w_wm1);
        r_out.src_y   <= clamp_src(r_su_y, r_su_py, r_su_in, w_hm1);
        r_out.in_lens <= r_su_in;
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

    `MLCR_ASSERT_DLY(a_lat_fwd, start && !busy, PIPE_LAT, o_valid, "accepted transaction lost")
    `MLCR_ASSERT_IMP(a_lat_back, o_valid, $past(start && !busy, PIPE_LAT), "result not requested")
    `MLCR_ASSERT_IMP(a_in_frame, o_valid, (o_result.src_x < r_w) && (o_result.src_y < r_h), "source outside frame")
    `MLCR_ASSERT_IMP(a_scale_nz, r_sc_v, r_sc_scale != '0, "zero scale reached divider")

endmodule
`default_nettype wire

### test/tb.sv
// Testbench for the lens coordinate remapper: APB setup, pixel stream, result checking
`timescale 1ns / 1ps
module tb;
    import mlcr_pkg::*;

    localparam int WAIT_LIMIT = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_item    i_item;
    logic        o_valid;
    t_out_item   o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    magnify_lens_coordinate_remap_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_valid(o_valid), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // lens settings as the block should hold them
    logic [16:0] lens_cx_frac, lens_cy_frac;
    logic [10:0] lens_mag;
    logic [14:0] lens_radius, lens_feather;
    logic [12:0] lens_w, lens_h;

    t_out_item   src_queue[$];
    int          mismatches;
    int          idle_cycles;
    bit          gaps_on;
    bit          timed_out;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    function automatic longint dim_clip(logic [12:0] d);
        if (d == 0) return 1;
        if (d > MAX_DIM) return MAX_DIM;
        return d;
    endfunction

    function automatic t_out_item remap_pixel(t_in_item px);
        t_out_item r;
        longint w, h, x, y, cx, cy, dx, dy, dist_q8, side, max_r, inner_r;
        longint blend, scale, sx, sy;
        bit in_radius;
        w = dim_clip(lens_w);
        h = dim_clip(lens_h);
        x = px.out_x;
        y = px.out_y;
        cx = (longint'(lens_cx_frac) * w) / 256;
        cy = (longint'(lens_cy_frac) * h) / 256;
        dx = x * 256 - cx;
        dy = y * 256 - cy;
        dist_q8 = root_floor(longint'(dx * dx) + longint'(dy * dy));
        side = (w > h) ? w : h;
        max_r = (longint'(lens_radius) * side) / 100;
        inner_r = (max_r * (25600 - longint'(lens_feather))) / 25600;
        in_radius = dist_q8 < max_r;
        if (in_radius) begin
            blend = 65536;
            if (dist_q8 > inner_r && lens_feather > 0)
                blend = ((max_r - dist_q8) * 65536) / (max_r - inner_r);
            scale = 4096 + ((longint'(lens_mag) - 256) * blend) / 4096;
            if (scale < 1) scale = 1;
            sx = (cx + (dx * 4096) / scale) / 256;
            sy = (cy + (dy * 4096) / scale) / 256;
        end else begin
            sx = x;
            sy = y;
        end
        if (sx < 0) sx = 0;
        if (sx > w - 1) sx = w - 1;
        if (sy < 0) sy = 0;
        if (sy > h - 1) sy = h - 1;
        r.src_x = sx[11:0];
        r.src_y = sy[11:0];
        r.in_lens = in_radius;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // result checker; the receiver cannot stall so every strobe is taken
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid) begin
            idle_cycles <= 0;
            if (src_queue.size() == 0) begin
                report_mismatch("result with no pending pixel");
            end else begin
                want = src_queue.pop_front();
                if (o_result.src_x !== want.src_x)
                    report_mismatch($sformatf("src_x got %0d want %0d",
                                              o_result.src_x, want.src_x));
                if (o_result.src_y !== want.src_y)
                    report_mismatch($sformatf("src_y got %0d want %0d",
                                              o_result.src_y, want.src_y));
                if (o_result.in_lens !== want.in_lens)
                    report_mismatch($sformatf("in_lens got %0b want %0b",
                                              o_result.in_lens, want.in_lens));
            end
        end else if (!(start && !busy)) begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles > WAIT_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("[magnify_lens_coordinate_remap_top] ERROR");
            $finish;
        end
    end

    // start stays high between back-to-back transactions; it drops for gaps and when the stream is drained
    task automatic send_pixel(logic [11:0] x, logic [11:0] y);
        t_in_item px;
        px.out_x = x;
        px.out_y = y;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= px;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        src_queue.push_back(remap_pixel(px));
    endtask

    task automatic drain;
        start <= 1'b0;
        while (src_queue.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_CENTER_X: lens_cx_frac = val[16:0];
            REG_CENTER_Y: lens_cy_frac = val[16:0];
            REG_MAG:      lens_mag     = val[10:0];
            REG_RADIUS:   lens_radius  = val[14:0];
            REG_FEATHER:  lens_feather = val[14:0];
            REG_WIDTH:    lens_w       = val[12:0];
            default:      lens_h       = val[12:0];
        endcase
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_lens(int cxf, int cyf, int mag, int rad, int fth, int w, int h);
        write_reg(REG_CENTER_X, cxf);
        write_reg(REG_CENTER_Y, cyf);
        write_reg(REG_MAG, mag);
        write_reg(REG_RADIUS, rad);
        write_reg(REG_FEATHER, fth);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // pixel near the lens center most of the time, anywhere otherwise
    task automatic send_random_pixel();
        int w, h, cx, cy, r;
        w = dim_clip(lens_w);
        h = dim_clip(lens_h);
        cx = (longint'(lens_cx_frac) * w) >> 16;
        cy = (longint'(lens_cy_frac) * h) >> 16;
        r = ((longint'(lens_radius) * ((w > h) ? w : h)) / 25600) + 2;
        if ($urandom_range(0, 3) != 0)
            send_pixel(12'(cx + $urandom_range(0, 2 * r) - r),
                       12'(cy + $urandom_range(0, 2 * r) - r));
        else
            send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
    endtask

    task automatic test_directed_defaults;
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd320, 12'd240);
        send_pixel(12'd400, 12'd240);
        send_pixel(12'd320, 12'd100);
        send_pixel(12'd500, 12'd300);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        drain();
    endtask

    task automatic test_directed_corners;
        // zero magnification, feather above 100 percent, odd frame sizes
        set_lens(65536, 0, 0, 25600, 25600, 0, 8191);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd2000);
        send_pixel(12'd4095, 12'd4095);
        drain();
        set_lens(0, 65536, 1280, 25600, 0, 4096, 1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd100, 12'd0);
        send_pixel(12'd4095, 12'd0);
        drain();
        set_lens(131071, 131071, 2047, 32767, 32767, 5000, 4096);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2048, 12'd2048);
        drain();
        set_lens(32768, 32768, 256, 0, 12800, 640, 480);
        send_pixel(12'd320, 12'd240);
        drain();
    endtask

    task automatic test_random_settings(int n_phases, int per_phase);
        for (int p = 0; p < n_phases; p++) begin
            set_lens($urandom_range(0, 131071), $urandom_range(0, 131071),
                     $urandom_range(0, 2047),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                 : $urandom_range(0, 7680),
                     $urandom_range(0, 32767),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                 : $urandom_range(1, 1024),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                 : $urandom_range(1, 1024));
            for (int i = 0; i < per_phase; i++) send_random_pixel();
            drain();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        idle_cycles = 0;
        gaps_on = 1'b1;
        timed_out = 1'b0;
        lens_cx_frac = RST_CENTER_X;
        lens_cy_frac = RST_CENTER_Y;
        lens_mag = RST_MAG;
        lens_radius = RST_RADIUS;
        lens_feather = RST_FEATHER;
        lens_w = RST_WIDTH;
        lens_h = RST_HEIGHT;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_defaults();
        test_directed_corners();
        test_random_settings(10, 80);
        gaps_on = 1'b0;
        test_random_settings(2, 100);

        if (mismatches == 0) begin
            $display("[magnify_lens_coordinate_remap_top] OK");
        end else begin
            $display("[magnify_lens_coordinate_remap_top] ERROR");
        end
        $finish;
    end
endmodule
